// ===== hdl/bsrc_pkg.sv =====
`timescale 1ns / 1ps

package bsrc_pkg;

  localparam int MAX_PROCESSES = 10;
  localparam int MAX_RESOURCES = 10;

  localparam int PIDX_W    = $clog2(MAX_PROCESSES);
  localparam int RIDX_W    = $clog2(MAX_RESOURCES);
  localparam int PCNT_W    = $clog2(MAX_PROCESSES + 1);
  localparam int RCNT_W    = $clog2(MAX_RESOURCES + 1);
  localparam int MEM_DEPTH = MAX_PROCESSES * MAX_RESOURCES;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  // available plus one allocation row per process, never wraps
  localparam int WORK_W    = $clog2(255 * (MAX_PROCESSES + 1) + 1);

  localparam int CFG_W = 4;

  typedef enum logic [2:0] {
    OP_ALLOC   = 3'd0,
    OP_MAX     = 3'd1,
    OP_AVAIL   = 3'd2,
    OP_REQUEST = 3'd3,
    OP_CHECK   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    STS_SAFE       = 3'd0,
    STS_UNSAFE     = 3'd1,
    STS_GRANTED    = 3'd2,
    STS_DENY_NEED  = 3'd3,
    STS_DENY_AVAIL = 3'd4
  } status_e;

  typedef enum logic {
    CFG_PROCESS_COUNT  = 1'b0,
    CFG_RESOURCE_COUNT = 1'b1
  } cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REQ_RD,
    ST_REQ_CMP,
    ST_INIT,
    ST_SEL,
    ST_FIT_RD,
    ST_FIT_CMP,
    ST_ADD_RD,
    ST_ADD,
    ST_COMMIT_RD,
    ST_COMMIT_WR,
    ST_EMIT
  } st_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] process;
    logic [3:0] resource;
    logic [7:0] amount;
    logic       last_element;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] process_id;
    logic       in_sequence;
    logic       last;
  } result_t;

  function automatic logic [ADDR_W-1:0] addr_of(logic [PIDX_W-1:0] p,
                                                logic [RIDX_W-1:0] r);
    return ADDR_W'(p) * ADDR_W'(MAX_RESOURCES) + ADDR_W'(r);
  endfunction

endpackage

// ===== hdl/bankers_safety_and_request_check.sv =====
`timescale 1ns / 1ps
// Banker's algorithm engine: allocation / max-claim / available stores, a
// staged resource request, and a safety check that emits the safe sequence.
// Input channel: a beat is taken at a rising edge with start_i high and
// busy_o low. Store writes (allocation, max claim, available) and non-final
// request elements finish in that edge and give no result; busy_o stays low.
// A final request element or a safety check raises busy_o until its last
// result beat has been issued.
// Result channel: one beat per cycle on result_o, marked by result_valid_o;
// a sequence is issued on consecutive cycles with last set on its final beat.
// The receiver cannot stall: every beat is valid for exactly one cycle.
// Datapath: the allocation and max-claim memories share one registered read
// address, so every element is read in one state and compared or added in the
// state that follows. A check loads work one resource at a time; each pass then
// visits the processes in turn, compares a not-yet-done one resource by
// resource and, if it fits, adds its allocation resource by resource. A request
// first checks need and availability per resource, then runs the check with the
// request applied and commits a grant per resource.
// Reset: all stores read as zero (per-entry valid bits on the memories),
// counts return to 10, no result is pending.
// Config: cfg_we_i writes process_count (index 0) or resource_count
// (index 1) at once; counts of 0 act as 1, counts above the maximum saturate.
module bankers_safety_and_request_check
  import bsrc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  item_t            item_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output logic             result_valid_o,
  output result_t          result_o
);

  // configuration
  logic [CFG_W-1:0]  pc_q, rc_q;
  logic [PCNT_W-1:0] np;
  logic [RCNT_W-1:0] nr;

  // sequencer
  st_e               state_q, state_d;
  logic              req_q, req_d;
  logic [PIDX_W-1:0] pid_q, pid_d;
  logic [PCNT_W-1:0] i_q, i_d;
  logic [RIDX_W-1:0] j_q, j_d;
  logic [PCNT_W-1:0] n_q, n_d;
  logic [PIDX_W-1:0] k_q, k_d;
  logic              prog_q, prog_d;
  logic              nfail_q, nfail_d;
  logic              afail_q, afail_d;
  logic              single_q, single_d;
  status_e           status_q, status_d;
  logic [MAX_PROCESSES-1:0] done_q, done_d;

  // stores and scratch
  logic [7:0]        avail_q  [MAX_RESOURCES];
  logic [7:0]        avail_d  [MAX_RESOURCES];
  logic [7:0]        staged_q [MAX_RESOURCES];
  logic [7:0]        staged_d [MAX_RESOURCES];
  logic [WORK_W-1:0] work_q   [MAX_RESOURCES];
  logic [WORK_W-1:0] work_d   [MAX_RESOURCES];
  logic [PIDX_W-1:0] seq_q    [MAX_PROCESSES];
  logic [PIDX_W-1:0] seq_d    [MAX_PROCESSES];

  // result register
  logic              res_valid_q, res_valid_d;
  result_t           res_q, res_d;

  // allocation and max-claim memories, one shared read address
  logic [7:0]           alloc_mem [MEM_DEPTH];
  logic [7:0]           max_mem   [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] alloc_vld_q, max_vld_q;
  logic                 alloc_rvld_q, max_rvld_q;
  logic [7:0]           alloc_rdata_q, max_rdata_q;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 alloc_we, max_we;
  logic [ADDR_W-1:0]    alloc_waddr, max_waddr;
  logic [7:0]           alloc_wdata;

  // datapath values shared by the sequencer states
  logic [7:0]        alloc_rd, max_rd, alloc_eff, stg_j, diff_eff;
  logic              last_j, blocked;
  logic [ADDR_W-1:0] in_addr;
  logic              in_ok_p, in_ok_r;
  logic [RIDX_W-1:0] in_r;
  logic [PIDX_W-1:0] i_idx;

  // effective counts: 0 acts as 1, saturate at the store size
  always_comb begin
    if (pc_q == '0) begin
      np = PCNT_W'(1);
    end else if (32'(pc_q) > MAX_PROCESSES) begin
      np = PCNT_W'(MAX_PROCESSES);
    end else begin
      np = PCNT_W'(pc_q);
    end
    if (rc_q == '0) begin
      nr = RCNT_W'(1);
    end else if (32'(rc_q) > MAX_RESOURCES) begin
      nr = RCNT_W'(MAX_RESOURCES);
    end else begin
      nr = RCNT_W'(rc_q);
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  assign in_ok_p = 32'(item_i.process) < MAX_PROCESSES;
  assign in_ok_r = 32'(item_i.resource) < MAX_RESOURCES;
  assign in_r    = RIDX_W'(item_i.resource);
  assign in_addr = addr_of(PIDX_W'(item_i.process), in_r);
  assign i_idx   = i_q[PIDX_W-1:0];

  // never-written entries read as zero
  assign alloc_rd = alloc_rvld_q ? alloc_rdata_q : 8'd0;
  assign max_rd   = max_rvld_q ? max_rdata_q : 8'd0;
  assign stg_j    = staged_q[j_q];
  assign last_j   = (RCNT_W'(j_q) + RCNT_W'(1)) == nr;

  // a pending request is seen by the check as already applied
  assign alloc_eff = (req_q && (i_q == PCNT_W'(pid_q))) ? alloc_rd + stg_j : alloc_rd;
  assign diff_eff  = max_rd - alloc_eff;
  assign blocked   = (max_rd > alloc_eff) && (WORK_W'(diff_eff) > work_q[j_q]);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    pid_d       = pid_q;
    i_d         = i_q;
    j_d         = j_q;
    n_d         = n_q;
    k_d         = k_q;
    prog_d      = prog_q;
    nfail_d     = nfail_q;
    afail_d     = afail_q;
    single_d    = single_q;
    status_d    = status_q;
    done_d      = done_q;
    avail_d     = avail_q;
    staged_d    = staged_q;
    work_d      = work_q;
    seq_d       = seq_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rd_addr     = '0;
    alloc_we    = 1'b0;
    alloc_waddr = in_addr;
    alloc_wdata = item_i.amount;
    max_we      = 1'b0;
    max_waddr   = in_addr;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (item_i.operation)
            OP_ALLOC: begin
              alloc_we = in_ok_p && in_ok_r;
            end
            OP_MAX: begin
              max_we = in_ok_p && in_ok_r;
            end
            OP_AVAIL: begin
              if (in_ok_r) begin
                avail_d[in_r] = item_i.amount;
              end
            end
            OP_REQUEST: begin
              if (in_ok_r) begin
                staged_d[in_r] = item_i.amount;
              end
              if (item_i.last_element) begin
                req_d   = 1'b1;
                pid_d   = PIDX_W'(item_i.process);
                j_d     = '0;
                nfail_d = 1'b0;
                afail_d = 1'b0;
                if (32'(item_i.process) >= 32'(np)) begin
                  status_d = STS_DENY_NEED;
                  single_d = 1'b1;
                  k_d      = '0;
                  state_d  = ST_EMIT;
                end else begin
                  state_d = ST_REQ_RD;
                end
              end
            end
            OP_CHECK: begin
              req_d   = 1'b0;
              j_d     = '0;
              state_d = ST_INIT;
            end
            default: begin
            end
          endcase
        end
      end

      ST_REQ_RD: begin
        rd_addr = addr_of(pid_q, j_q);
        state_d = ST_REQ_CMP;
      end

      ST_REQ_CMP: begin
        // need is negative when allocation tops the claim: any request fails
        nfail_d = nfail_q || (max_rd < alloc_rd) || (stg_j > (max_rd - alloc_rd));
        afail_d = afail_q || (stg_j > avail_q[j_q]);
        if (last_j) begin
          j_d = '0;
          if (nfail_d) begin
            status_d = STS_DENY_NEED;
            single_d = 1'b1;
            k_d      = '0;
            state_d  = ST_EMIT;
          end else if (afail_d) begin
            status_d = STS_DENY_AVAIL;
            single_d = 1'b1;
            k_d      = '0;
            state_d  = ST_EMIT;
          end else begin
            state_d = ST_INIT;
          end
        end else begin
          j_d     = j_q + RIDX_W'(1);
          state_d = ST_REQ_RD;
        end
      end

      ST_INIT: begin
        work_d[j_q] = WORK_W'(avail_q[j_q]) - (req_q ? WORK_W'(stg_j) : WORK_W'(0));
        if (last_j) begin
          j_d     = '0;
          i_d     = '0;
          n_d     = '0;
          prog_d  = 1'b0;
          done_d  = '0;
          state_d = ST_SEL;
        end else begin
          j_d = j_q + RIDX_W'(1);
        end
      end

      ST_SEL: begin
        if (i_q == np) begin
          if (prog_q && (n_q < np)) begin
            i_d    = '0;
            prog_d = 1'b0;
          end else if (n_q == np) begin
            if (req_q) begin
              j_d     = '0;
              state_d = ST_COMMIT_RD;
            end else begin
              status_d = STS_SAFE;
              single_d = 1'b0;
              k_d      = '0;
              state_d  = ST_EMIT;
            end
          end else begin
            status_d = STS_UNSAFE;
            single_d = 1'b1;
            k_d      = '0;
            state_d  = ST_EMIT;
          end
        end else if (done_q[i_idx]) begin
          i_d = i_q + PCNT_W'(1);
        end else begin
          j_d     = '0;
          state_d = ST_FIT_RD;
        end
      end

      ST_FIT_RD: begin
        rd_addr = addr_of(i_idx, j_q);
        state_d = ST_FIT_CMP;
      end

      ST_FIT_CMP: begin
        if (blocked) begin
          i_d     = i_q + PCNT_W'(1);
          state_d = ST_SEL;
        end else if (last_j) begin
          j_d     = '0;
          state_d = ST_ADD_RD;
        end else begin
          j_d     = j_q + RIDX_W'(1);
          state_d = ST_FIT_RD;
        end
      end

      ST_ADD_RD: begin
        rd_addr = addr_of(i_idx, j_q);
        state_d = ST_ADD;
      end

      ST_ADD: begin
        work_d[j_q] = work_q[j_q] + WORK_W'(alloc_eff);
        if (last_j) begin
          done_d[i_idx]                = 1'b1;
          seq_d[n_q[PIDX_W-1:0]]       = i_idx;
          n_d                          = n_q + PCNT_W'(1);
          prog_d                       = 1'b1;
          i_d                          = i_q + PCNT_W'(1);
          state_d                      = ST_SEL;
        end else begin
          j_d     = j_q + RIDX_W'(1);
          state_d = ST_ADD_RD;
        end
      end

      ST_COMMIT_RD: begin
        rd_addr = addr_of(pid_q, j_q);
        state_d = ST_COMMIT_WR;
      end

      ST_COMMIT_WR: begin
        alloc_we     = 1'b1;
        alloc_waddr  = addr_of(pid_q, j_q);
        alloc_wdata  = alloc_rd + stg_j;
        avail_d[j_q] = avail_q[j_q] - stg_j;
        if (last_j) begin
          status_d = STS_GRANTED;
          single_d = 1'b0;
          k_d      = '0;
          state_d  = ST_EMIT;
        end else begin
          j_d     = j_q + RIDX_W'(1);
          state_d = ST_COMMIT_RD;
        end
      end

      ST_EMIT: begin
        res_valid_d         = 1'b1;
        res_d.status        = status_q;
        res_d.process_id    = single_q ? 4'd0 : 4'(seq_q[k_q]);
        res_d.in_sequence   = !single_q;
        res_d.last          = single_q || ((PCNT_W'(k_q) + PCNT_W'(1)) == n_q);
        if (res_d.last) begin
          state_d = ST_IDLE;
          // drop the staged request once it has been evaluated
          if (req_q) begin
            for (int r = 0; r < MAX_RESOURCES; r++) begin
              staged_d[r] = 8'd0;
            end
          end
        end else begin
          k_d = k_q + PIDX_W'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control, configuration, small stores and memory valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pc_q         <= CFG_W'(10);
      rc_q         <= CFG_W'(10);
      req_q        <= 1'b0;
      pid_q        <= '0;
      i_q          <= '0;
      j_q          <= '0;
      n_q          <= '0;
      k_q          <= '0;
      prog_q       <= 1'b0;
      nfail_q      <= 1'b0;
      afail_q      <= 1'b0;
      single_q     <= 1'b0;
      status_q     <= STS_SAFE;
      done_q       <= '0;
      res_valid_q  <= 1'b0;
      alloc_vld_q  <= '0;
      max_vld_q    <= '0;
      alloc_rvld_q <= 1'b0;
      max_rvld_q   <= 1'b0;
      for (int r = 0; r < MAX_RESOURCES; r++) begin
        avail_q[r]  <= 8'd0;
        staged_q[r] <= 8'd0;
      end
    end else begin
      state_q      <= state_d;
      req_q        <= req_d;
      pid_q        <= pid_d;
      i_q          <= i_d;
      j_q          <= j_d;
      n_q          <= n_d;
      k_q          <= k_d;
      prog_q       <= prog_d;
      nfail_q      <= nfail_d;
      afail_q      <= afail_d;
      single_q     <= single_d;
      status_q     <= status_d;
      done_q       <= done_d;
      res_valid_q  <= res_valid_d;
      avail_q      <= avail_d;
      staged_q     <= staged_d;
      alloc_rvld_q <= alloc_vld_q[rd_addr];
      max_rvld_q   <= max_vld_q[rd_addr];
      if (alloc_we) begin
        alloc_vld_q[alloc_waddr] <= 1'b1;
      end
      if (max_we) begin
        max_vld_q[max_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PROCESS_COUNT:  pc_q <= cfg_wdata_i;
          CFG_RESOURCE_COUNT: rc_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    work_q <= work_d;
    seq_q  <= seq_d;
  end

  // memories: one write, one registered read each
  always_ff @(posedge clk_i) begin
    if (alloc_we) begin
      alloc_mem[alloc_waddr] <= alloc_wdata;
    end
    if (max_we) begin
      max_mem[max_waddr] <= item_i.amount;
    end
    alloc_rdata_q <= alloc_mem[rd_addr];
    max_rdata_q   <= max_mem[rd_addr];
  end

  // a safe sequence goes out as one unbroken run of beats
  a_seq_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |=> result_valid_o && result_o.in_sequence)
    else $error("safe sequence broken before its last beat");

  // a status-only beat always closes the run
  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.in_sequence |-> result_o.last)
    else $error("status beat without last");

  // never more sequence entries than processes in use
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEL || state_q == ST_FIT_RD || state_q == ST_FIT_CMP ||
     state_q == ST_ADD_RD || state_q == ST_ADD) |-> n_q <= np && i_q <= np)
    else $error("sequence counter beyond process count");

  // no commit of a request that failed its need or availability check
  a_commit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COMMIT_WR |-> req_q && !nfail_q && !afail_q)
    else $error("commit of a denied request");

endmodule

// ===== sim/bankers_checker.sv =====
`timescale 1ns / 1ps

module bankers_checker
  import bsrc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  item_t            item_i,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             result_valid_i,
  input  result_t          result_i,
  output int               fail_cnt_o,
  output int               pending_o,
  output int               beats_o
);

  localparam int REPORT_LIMIT = 10;

  logic [7:0] alloc_mem  [MAX_PROCESSES][MAX_RESOURCES];
  logic [7:0] claim_mem  [MAX_PROCESSES][MAX_RESOURCES];
  logic [7:0] avail_vec  [MAX_RESOURCES];
  logic [7:0] staged_vec [MAX_RESOURCES];
  logic [3:0] proc_cnt;
  logic [3:0] res_cnt;
  logic [3:0] safe_order [MAX_PROCESSES];
  result_t    outcome_q  [$];
  int         mismatches;
  int         beats;

  function automatic int eff_count(logic [3:0] v, int hi);
    if (v == 0) return 1;
    if (int'(v) > hi) return hi;
    return int'(v);
  endfunction

  function automatic int need_of(int p, int r);
    return int'(claim_mem[p][r]) - int'(alloc_mem[p][r]);
  endfunction

  // Fill safe_order pass by pass; return how many processes could finish.
  function automatic int find_safe_order();
    int  np;
    int  nr;
    int  len;
    int  work [MAX_RESOURCES];
    bit  done [MAX_PROCESSES];
    bit  progressed;
    bit  fits;
    np  = eff_count(proc_cnt, MAX_PROCESSES);
    nr  = eff_count(res_cnt, MAX_RESOURCES);
    len = 0;
    for (int j = 0; j < MAX_RESOURCES; j++) work[j] = int'(avail_vec[j]);
    for (int i = 0; i < MAX_PROCESSES; i++) done[i] = 1'b0;
    while (len < np) begin
      progressed = 1'b0;
      for (int i = 0; i < np; i++) begin
        if (!done[i]) begin
          fits = 1'b1;
          for (int j = 0; j < nr; j++)
            if (need_of(i, j) > work[j]) fits = 1'b0;
          if (fits) begin
            for (int j = 0; j < nr; j++) work[j] += int'(alloc_mem[i][j]);
            safe_order[len] = 4'(i);
            len++;
            done[i] = 1'b1;
            progressed = 1'b1;
          end
        end
      end
      if (!progressed) break;
    end
    return len;
  endfunction

  function automatic void push_single(status_e st);
    result_t r;
    r.status      = st;
    r.process_id  = '0;
    r.in_sequence = 1'b0;
    r.last        = 1'b1;
    outcome_q.push_back(r);
  endfunction

  function automatic void push_order(status_e st, int len);
    result_t r;
    for (int k = 0; k < len; k++) begin
      r.status      = st;
      r.process_id  = safe_order[k];
      r.in_sequence = 1'b1;
      r.last        = (k == len - 1);
      outcome_q.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict
    int      np;
    int      nr;
    int      len;
    int      pid;
    bit      over_need;
    bit      over_avail;
    result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PROCESSES; i++)
        for (int j = 0; j < MAX_RESOURCES; j++) begin
          alloc_mem[i][j] = '0;
          claim_mem[i][j] = '0;
        end
      for (int j = 0; j < MAX_RESOURCES; j++) begin
        avail_vec[j]  = '0;
        staged_vec[j] = '0;
      end
      proc_cnt = 4'(MAX_PROCESSES);
      res_cnt  = 4'(MAX_RESOURCES);
      outcome_q.delete();
      mismatches = 0;
      beats      = 0;
    end else begin
      // compare an issued beat against the oldest outstanding one
      if (result_valid_i) begin
        beats++;
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("[%0t] unexpected result beat: status %0d pid %0d seq %0b last %0b",
                     $realtime, result_i.status, result_i.process_id,
                     result_i.in_sequence, result_i.last);
        end else begin
          want = outcome_q.pop_front();
          if (result_i.status !== want.status || result_i.process_id !== want.process_id ||
              result_i.in_sequence !== want.in_sequence || result_i.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("[%0t] result mismatch: expected status %0d pid %0d seq %0b last %0b,",
                       $realtime, want.status, want.process_id, want.in_sequence, want.last);
              $display("    got status %0d pid %0d seq %0b last %0b",
                       result_i.status, result_i.process_id, result_i.in_sequence,
                       result_i.last);
            end
          end
        end
      end

      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_PROCESS_COUNT) proc_cnt = cfg_wdata_i;
        else res_cnt = cfg_wdata_i;
      end

      if (start_i && !busy_i) begin
        np = eff_count(proc_cnt, MAX_PROCESSES);
        nr = eff_count(res_cnt, MAX_RESOURCES);
        case (item_i.operation)
          OP_ALLOC:
            if (item_i.process < MAX_PROCESSES && item_i.resource < MAX_RESOURCES)
              alloc_mem[item_i.process][item_i.resource] = item_i.amount;
          OP_MAX:
            if (item_i.process < MAX_PROCESSES && item_i.resource < MAX_RESOURCES)
              claim_mem[item_i.process][item_i.resource] = item_i.amount;
          OP_AVAIL:
            if (item_i.resource < MAX_RESOURCES) avail_vec[item_i.resource] = item_i.amount;
          OP_REQUEST: begin
            if (item_i.resource < MAX_RESOURCES) staged_vec[item_i.resource] = item_i.amount;
            if (item_i.last_element) begin
              pid = int'(item_i.process);
              if (pid >= np) begin
                push_single(STS_DENY_NEED);
              end else begin
                over_need  = 1'b0;
                over_avail = 1'b0;
                for (int j = 0; j < nr; j++) begin
                  if (int'(staged_vec[j]) > need_of(pid, j)) over_need = 1'b1;
                  if (staged_vec[j] > avail_vec[j]) over_avail = 1'b1;
                end
                if (over_need) begin
                  push_single(STS_DENY_NEED);
                end else if (over_avail) begin
                  push_single(STS_DENY_AVAIL);
                end else begin
                  // apply tentatively, roll back if no safe order exists
                  for (int j = 0; j < nr; j++) begin
                    avail_vec[j]      = avail_vec[j] - staged_vec[j];
                    alloc_mem[pid][j] = alloc_mem[pid][j] + staged_vec[j];
                  end
                  len = find_safe_order();
                  if (len == np) begin
                    push_order(STS_GRANTED, len);
                  end else begin
                    for (int j = 0; j < nr; j++) begin
                      avail_vec[j]      = avail_vec[j] + staged_vec[j];
                      alloc_mem[pid][j] = alloc_mem[pid][j] - staged_vec[j];
                    end
                    push_single(STS_UNSAFE);
                  end
                end
              end
              for (int j = 0; j < MAX_RESOURCES; j++) staged_vec[j] = '0;
            end
          end
          OP_CHECK: begin
            len = find_safe_order();
            if (len == np) push_order(STS_SAFE, len);
            else push_single(STS_UNSAFE);
          end
          default: ;
        endcase
      end
    end
    fail_cnt_o <= mismatches;
    pending_o  <= outcome_q.size();
    beats_o    <= beats;
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bsrc_pkg::*;

  // Watchdog: a request at 10x10 gives no beat while it runs, so going past
  // STALL_LIMIT with nothing moving means the block hung.
  localparam int STALL_LIMIT = 20000;
  // Quiet time after the last beat: one worst-case check and then some.
  localparam int TAIL_CYCLES = 2500;
  localparam int PHASE_BEATS = 18;
  // Preload the whole in-use part of the tables only while it stays small.
  localparam int SETUP_LIMIT = 8;
  localparam int NUM_PHASES  = 5;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // Count settings per phase: 0 and 15 probe the clamp, the last is random.
  localparam logic [3:0] PHASE_PROCS [NUM_PHASES] = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd4};
  localparam logic [3:0] PHASE_RES   [NUM_PHASES] = '{4'd1, 4'd15, 4'd0, 4'd2, 4'd4};
  // Sender idle percentage per phase.
  localparam int         PHASE_IDLE  [NUM_PHASES] = '{0, 50, 18, 0, 50};

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             start     = 1'b0;
  logic             busy;
  item_t            item      = '0;
  logic             cfg_we    = 1'b0;
  logic             cfg_idx   = CFG_PROCESS_COUNT;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             res_valid;
  result_t          res;

  int fail_cnt;
  int pending;
  int beats_seen;
  int idle_pct     = 0;
  int beats_sent   = 0;
  int evals        = 0;
  int stall_cycles = 0;
  int nproc        = MAX_PROCESSES;
  int nres         = MAX_RESOURCES;

  bankers_safety_and_request_check u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_o         (busy),
    .item_i         (item),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_o (res_valid),
    .result_o       (res)
  );

  bankers_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .item_i         (item),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_i (res_valid),
    .result_i       (res),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending),
    .beats_o        (beats_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Reset the stall counter on any accepted beat, config write or result.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || res_valid || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  function automatic item_t beat_of(logic [2:0] op, int p, int r, int amt, bit fin);
    item_t it;
    it.operation    = op;
    it.process      = 4'(p);
    it.resource     = 4'(r);
    it.amount       = 8'(amt);
    it.last_element = fin;
    return it;
  endfunction

  // Present one beat, hold it until taken, then maybe idle the sender.
  task automatic send_beat(item_t it);
    item  <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    beats_sent++;
    if (it.operation == OP_CHECK || (it.operation == OP_REQUEST && it.last_element))
      evals++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Drop start and wait until every outstanding result has come out.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  // Write one count register; track the clamped value for stimulus shaping.
  task automatic write_count(cfg_e idx, logic [3:0] v);
    int eff;
    eff = (v == 0) ? 1 : int'(v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_PROCESS_COUNT) nproc = (eff > MAX_PROCESSES) ? MAX_PROCESSES : eff;
    else nres = (eff > MAX_RESOURCES) ? MAX_RESOURCES : eff;
  endtask

  initial begin : stimulus
    int            goal;
    int            pick;
    int            p;
    int            amt;
    int            base;
    logic [3:0]    pc;
    logic [3:0]    rc;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset counts (10 processes, 10 resources).
    send_beat(beat_of(OP_CHECK, 0, 0, 0, 1'b0));      // empty tables: trivially safe
    send_beat(beat_of(OP_ALLOC, 0, 0, 255, 1'b0));    // allocation above claim
    send_beat(beat_of(OP_MAX, 9, 9, 255, 1'b0));
    send_beat(beat_of(OP_CHECK, 0, 0, 0, 1'b0));      // p9 can never fit: unsafe
    send_beat(beat_of(OP_AVAIL, 0, 9, 255, 1'b0));
    send_beat(beat_of(OP_CHECK, 0, 0, 0, 1'b0));
    send_beat(beat_of(OP_ALLOC, 15, 0, 7, 1'b0));     // writes outside the store
    send_beat(beat_of(OP_MAX, 0, 15, 9, 1'b0));
    send_beat(beat_of(OP_AVAIL, 0, 12, 3, 1'b0));
    send_beat(beat_of(OP_REQUEST, 3, 12, 5, 1'b0));   // staged element outside the store
    send_beat(beat_of(OP_REQUEST, 3, 0, 1, 1'b1));    // exceeds need
    send_beat(beat_of(OP_REQUEST, 12, 0, 0, 1'b1));   // process not in use
    send_beat(beat_of(OP_REQUEST, 9, 9, 200, 1'b1));  // granted
    send_beat(beat_of(OP_MAX, 1, 1, 100, 1'b0));
    send_beat(beat_of(OP_REQUEST, 1, 1, 50, 1'b1));   // nothing available
    send_beat(beat_of(OP_AVAIL, 0, 1, 60, 1'b0));
    send_beat(beat_of(OP_MAX, 2, 1, 100, 1'b0));
    send_beat(beat_of(OP_REQUEST, 1, 1, 60, 1'b1));   // leaves no safe order: roll back
    for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++)
      send_beat(beat_of(3'(op), $urandom_range(15), $urandom_range(15),
                        $urandom_range(255), 1'($urandom_range(1))));
    send_beat(beat_of(OP_CHECK, 0, 0, 0, 1'b1));
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      pc = PHASE_PROCS[ph];
      rc = PHASE_RES[ph];
      if (ph == NUM_PHASES - 1) begin
        pc = 4'($urandom_range(2, 6));
        rc = 4'($urandom_range(1, 5));
      end
      write_count(CFG_PROCESS_COUNT, pc);
      write_count(CFG_RESOURCE_COUNT, rc);
      idle_pct = PHASE_IDLE[ph];

      // Preload a consistent state so checks and requests get past the
      // first compare: claim at or above allocation, a little available.
      if (nproc * nres <= SETUP_LIMIT) begin
        for (int i = 0; i < nproc; i++)
          for (int j = 0; j < nres; j++) begin
            base = $urandom_range(0, 3);
            send_beat(beat_of(OP_ALLOC, i, j, base, 1'b0));
            send_beat(beat_of(OP_MAX, i, j, base + $urandom_range(0, 4), 1'b0));
          end
        for (int j = 0; j < nres; j++)
          send_beat(beat_of(OP_AVAIL, 0, j, $urandom_range(0, 5), 1'b0));
      end

      goal = beats_sent + PHASE_BEATS;
      while (beats_sent < goal) begin
        pick = $urandom_range(99);
        p    = $urandom_range(nproc - 1);
        amt  = ($urandom_range(7) == 0) ? $urandom_range(255) : $urandom_range(6);
        if (pick < 12) begin
          send_beat(beat_of(OP_ALLOC, p, $urandom_range(nres - 1), amt, 1'b0));
        end else if (pick < 24) begin
          send_beat(beat_of(OP_MAX, p, $urandom_range(nres - 1), amt, 1'b0));
        end else if (pick < 32) begin
          send_beat(beat_of(OP_AVAIL, 0, $urandom_range(nres - 1), amt, 1'b0));
        end else if (pick < 50) begin
          send_beat(beat_of(OP_CHECK, 0, 0, 0, 1'b0));
        end else if (pick < 85) begin
          // well-formed request: one element per resource, last on the final
          for (int j = 0; j < nres; j++)
            send_beat(beat_of(OP_REQUEST, p, j,
                              ($urandom_range(9) == 0) ? $urandom_range(255)
                                                       : $urandom_range(2),
                              j == nres - 1));
        end else begin
          send_beat(beat_of(3'($urandom_range(7)), $urandom_range(15), $urandom_range(15),
                            $urandom_range(255), 1'($urandom_range(1))));
        end
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d input beats with %0d checks/requests evaluated", beats_sent, evals);
    $display("saw %0d result beats over %0d count settings plus the reset setting",
             beats_seen, NUM_PHASES);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d result mismatches", fail_cnt);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
